// ----- rtl/ihex_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser - shared definitions
// Parse phases, result kinds, widths and the result record type.
// ----------------------------------------------------------------------------
package ihex_pkg;

   localparam int ADDR_W   = 20;
   localparam int SIZE_W   = 21;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 16;

   localparam logic [SIZE_W-1:0] FLASH_SIZE_RESET = SIZE_W'(1048576);
   localparam logic [BYTE_W-1:0] CHAR_COLON       = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE     = 8'h0A;

   localparam logic [7:0] REC_DATA    = 8'h00;
   localparam logic [7:0] REC_EOF     = 8'h01;
   localparam logic [7:0] REC_SEGMENT = 8'h02;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_COUNT   = 3'd1,
      PH_OFFSET  = 3'd2,
      PH_TYPE    = 3'd3,
      PH_DATA    = 3'd4,
      PH_SEGMENT = 3'd5,
      PH_TRAIL   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_DATA_BYTE   = 3'd0,
      KIND_DATA_DONE   = 3'd1,
      KIND_SEGMENT     = 3'd2,
      KIND_END         = 3'd3,
      KIND_NOT_RECORD  = 3'd4,
      KIND_BAD_DIGIT   = 3'd5,
      KIND_BAD_TYPE    = 3'd6,
      KIND_TOO_LARGE   = 3'd7
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   address;
      logic [BYTE_W-1:0]   data_byte;
      logic [BYTE_W-1:0]   byte_count;
      logic [ADDR_W-1:0]   highest_address;
   } result_type;

endpackage

// ----- rtl/intel_hex_record_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Decodes HEX text one character per item; emits data bytes with their
// 20-bit addresses and one status item per record.
//
//   port group | dir | handshake          | payload
//   req_       | in  | req_valid/req_stall| req_character[7:0]
//   rsp_       | out | rsp_valid/rsp_stall| kind, address, data, count, highest
//   csr_       | in  | csr_write_enable   | csr_flash_size[20:0]
//
// One character is accepted per cycle while req_stall is low; its result is
// registered in the output register, or in a skid register that holds one
// more result when the output is stalled; input is stalled only when both
// are full. Synchronous reset clears the parse state and restores flash_size
// to 1 MiB. The first error halts the parser (no further results) until reset.
// ----------------------------------------------------------------------------
module intel_hex_record_parser
   import ihex_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_character,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_result_kind,
   output logic [ADDR_W-1:0]   rsp_address,
   output logic [BYTE_W-1:0]   rsp_data_byte,
   output logic [BYTE_W-1:0]   rsp_byte_count,
   output logic [ADDR_W-1:0]   rsp_highest_address,
   input  logic                csr_write_enable,
   input  logic [SIZE_W-1:0]   csr_flash_size
);

   phase_type             phase_ff, phase_in;
   logic [1:0]            digit_ff, digit_in;
   logic [7:0]            count_ff, count_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [7:0]            type_ff, type_in;
   logic [OFFSET_W-1:0]   segment_ff, segment_in;
   logic [3:0]            base_ff, base_in;
   logic [7:0]            acc_ff, acc_in;
   logic [7:0]            done_ff, done_in;
   logic [ADDR_W-1:0]     highest_ff, highest_in;
   logic                  halted_ff, halted_in;
   logic [SIZE_W-1:0]     flash_size_ff;

   result_type            main_ff, skid_ff, res;
   logic                  main_valid_ff, skid_valid_ff, res_valid;

   logic                  accept;
   logic                  is_hex;
   logic [3:0]            nib;
   logic [ADDR_W-1:0]     start_addr;
   logic [ADDR_W-1:0]     byte_addr;
   logic [SIZE_W-1:0]     end_addr;
   logic [7:0]            type_new;
   logic [7:0]            acc_new;
   logic                  out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign out_free  = !main_valid_ff || !rsp_stall;

   // digit decode: 0-9, A-F, a-f only
   always_comb begin
      is_hex = 1'b1;
      nib    = 4'd0;
      if (req_character >= 8'h30 && req_character <= 8'h39) begin
         nib = 4'(req_character - 8'h30);
      end else if (req_character >= 8'h41 && req_character <= 8'h46) begin
         nib = 4'(req_character - 8'h37);
      end else if (req_character >= 8'h61 && req_character <= 8'h66) begin
         nib = 4'(req_character - 8'h57);
      end else begin
         is_hex = 1'b0;
      end
   end

   assign start_addr = {base_ff, offset_ff};
   assign byte_addr  = start_addr + ADDR_W'(done_ff);
   assign end_addr   = SIZE_W'(start_addr) + SIZE_W'(count_ff);
   assign type_new   = {type_ff[3:0], nib};
   assign acc_new    = {acc_ff[3:0], nib};

   always_comb begin
      phase_in   = phase_ff;
      digit_in   = digit_ff;
      count_in   = count_ff;
      offset_in  = offset_ff;
      type_in    = type_ff;
      segment_in = segment_ff;
      base_in    = base_ff;
      acc_in     = acc_ff;
      done_in    = done_ff;
      highest_in = highest_ff;
      halted_in  = halted_ff;

      res_valid           = 1'b0;
      res.kind            = KIND_BAD_DIGIT;
      res.address         = start_addr;
      res.data_byte       = '0;
      res.byte_count      = count_ff;
      res.highest_address = highest_ff;

      if (accept && !halted_ff) begin
         if (phase_ff == PH_START) begin
            digit_in   = '0;
            count_in   = '0;
            offset_in  = '0;
            type_in    = '0;
            segment_in = '0;
            acc_in     = '0;
            done_in    = '0;
            if (req_character == CHAR_COLON) begin
               phase_in = PH_COUNT;
            end else begin
               halted_in      = 1'b1;
               res_valid      = 1'b1;
               res.kind       = KIND_NOT_RECORD;
               res.address    = {base_ff, {OFFSET_W{1'b0}}};
               res.byte_count = '0;
            end
         end else if (phase_ff == PH_TRAIL) begin
            if (req_character == CHAR_NEWLINE) begin
               res_valid = 1'b1;
               if (type_ff == REC_DATA) begin
                  res.kind = KIND_DATA_DONE;
               end else if (type_ff == REC_SEGMENT) begin
                  res.kind = KIND_SEGMENT;
                  base_in  = segment_ff[15:12];
               end else begin
                  res.kind = KIND_END;
               end
               phase_in = PH_START;
            end
         end else if (!is_hex) begin
            halted_in = 1'b1;
            res_valid = 1'b1;
            res.kind  = KIND_BAD_DIGIT;
         end else begin
            unique case (phase_ff)
               PH_COUNT: begin
                  count_in = {count_ff[3:0], nib};
                  if (digit_ff == 2'd1) begin
                     digit_in = '0;
                     phase_in = PH_OFFSET;
                  end else begin
                     digit_in = 2'd1;
                  end
               end
               PH_OFFSET: begin
                  offset_in = {offset_ff[11:0], nib};
                  digit_in  = digit_ff + 2'd1;
                  if (digit_ff == 2'd3) begin
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  type_in = type_new;
                  if (digit_ff == 2'd0) begin
                     digit_in = 2'd1;
                  end else begin
                     digit_in = '0;
                     if (type_new == REC_DATA) begin
                        if (count_ff == '0) begin
                           phase_in = PH_TRAIL;
                        end else if (end_addr > flash_size_ff) begin
                           halted_in = 1'b1;
                           res_valid = 1'b1;
                           res.kind  = KIND_TOO_LARGE;
                        end else begin
                           phase_in = PH_DATA;
                        end
                     end else if (type_new == REC_EOF) begin
                        phase_in = PH_TRAIL;
                     end else if (type_new == REC_SEGMENT) begin
                        phase_in = PH_SEGMENT;
                     end else begin
                        halted_in = 1'b1;
                        res_valid = 1'b1;
                        res.kind  = KIND_BAD_TYPE;
                     end
                  end
               end
               PH_DATA: begin
                  acc_in = acc_new;
                  if (digit_ff == 2'd0) begin
                     digit_in = 2'd1;
                  end else begin
                     digit_in = '0;
                     if (byte_addr > highest_ff) begin
                        highest_in = byte_addr;
                     end
                     done_in = done_ff + 8'd1;
                     if (done_ff + 8'd1 == count_ff) begin
                        phase_in = PH_TRAIL;
                     end
                     res_valid           = 1'b1;
                     res.kind            = KIND_DATA_BYTE;
                     res.address         = byte_addr;
                     res.data_byte       = acc_new;
                     res.highest_address = (byte_addr > highest_ff) ? byte_addr
                                                                    : highest_ff;
                  end
               end
               PH_SEGMENT: begin
                  segment_in = {segment_ff[11:0], nib};
                  digit_in   = digit_ff + 2'd1;
                  if (digit_ff == 2'd3) begin
                     phase_in = PH_TRAIL;
                  end
               end
               default: begin
                  phase_in = PH_START;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         digit_ff      <= '0;
         count_ff      <= '0;
         offset_ff     <= '0;
         type_ff       <= '0;
         segment_ff    <= '0;
         base_ff       <= '0;
         acc_ff        <= '0;
         done_ff       <= '0;
         highest_ff    <= '0;
         halted_ff     <= 1'b0;
         flash_size_ff <= FLASH_SIZE_RESET;
      end else begin
         phase_ff   <= phase_in;
         digit_ff   <= digit_in;
         count_ff   <= count_in;
         offset_ff  <= offset_in;
         type_ff    <= type_in;
         segment_ff <= segment_in;
         base_ff    <= base_in;
         acc_ff     <= acc_in;
         done_ff    <= done_in;
         highest_ff <= highest_in;
         halted_ff  <= halted_in;
         if (csr_write_enable) begin
            flash_size_ff <= csr_flash_size;
         end
      end
   end

   // output register plus skid; input stalls only while the skid is full
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= res_valid;
         end
      end else if (res_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         main_ff <= skid_valid_ff ? skid_ff : res;
      end else if (res_valid) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid           = main_valid_ff;
   assign rsp_result_kind     = main_ff.kind;
   assign rsp_address         = main_ff.address;
   assign rsp_data_byte       = main_ff.data_byte;
   assign rsp_byte_count      = main_ff.byte_count;
   assign rsp_highest_address = main_ff.highest_address;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds an item while output register is empty");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !res_valid)
      else $error("result produced while halted");

   a_data_under_highest: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && main_ff.kind == KIND_DATA_BYTE)
         |-> main_ff.address <= main_ff.highest_address)
      else $error("data address above reported highest address");

   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && main_ff.kind != KIND_DATA_BYTE) |-> main_ff.data_byte == '0)
      else $error("status item carries nonzero data");

endmodule
